// ===== rtl/stt_pkg.sv =====
package stt_pkg;

  localparam int MaxResults = 3;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOT  = 2'd2;

  localparam logic [1:0] CLS_IDENT  = 2'd0;
  localparam logic [1:0] CLS_NUMBER = 2'd1;
  localparam logic [1:0] CLS_STRING = 2'd2;
  localparam logic [1:0] CLS_OP     = 2'd3;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [1:0]  token_class;
    logic [7:0]  token_char;
    logic [15:0] tokens_so_far;
    logic        was_truncated;
    logic        last_of_run;
  } tok_t;

  typedef struct packed {
    tok_t [MaxResults-1:0] slot;
    logic [1:0]            count;
  } step_t;

endpackage

// ===== rtl/stt_byte_if.sv =====
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// ===== rtl/stt_tok_if.sv =====
interface stt_tok_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [1:0]  token_class;
  logic [7:0]  token_char;
  logic [15:0] tokens_so_far;
  logic        was_truncated;
  logic        last_of_run;

  modport source (output valid, output item_kind, output token_class, output token_char,
                  output tokens_so_far, output was_truncated, output last_of_run,
                  input ready);
  modport sink (input valid, input item_kind, input token_class, input token_char,
                input tokens_so_far, input was_truncated, input last_of_run,
                output ready);
endinterface

// ===== rtl/stt_scan.sv =====
module stt_scan #(
  parameter int TOKEN_CHARS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  input  logic           fire,
  input  logic [7:0]     text_byte,
  output stt_pkg::step_t step
);
  import stt_pkg::*;

  localparam int CW = $clog2(TOKEN_CHARS + 1);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_IDENT   = 3'd2;
  localparam logic [2:0] MODE_NUMBER  = 3'd3;
  localparam logic [2:0] MODE_STRING  = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_BANG  = 8'd33;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] CH_GT    = 8'd62;
  localparam logic [7:0] CH_US    = 8'd95;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic tok_t mk(input logic [1:0] kind, input logic [1:0] cls,
                              input logic [7:0] ch, input logic [15:0] cnt,
                              input logic tr);
    tok_t t;
    t.item_kind     = kind;
    t.token_class   = cls;
    t.token_char    = ch;
    t.tokens_so_far = cnt;
    t.was_truncated = tr;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

  logic [15:0]   limit;
  logic [2:0]    mode, mode_next;
  logic          pend, pend_next;
  logic [15:0]   count, count_next;
  logic [CW-1:0] chars, chars_next;
  logic          ovf, ovf_next;

  always_comb begin
    logic [7:0] c;
    logic [1:0] n;
    logic       add_a, end_a, fresh;
    logic [1:0] cls_a;
    step_t      r;
    c         = text_byte;
    n         = 2'd0;
    r         = '0;
    add_a     = 1'b0;
    end_a     = 1'b0;
    fresh     = 1'b0;
    cls_a     = CLS_OP;
    mode_next  = mode;
    pend_next  = pend;
    count_next = count;
    chars_next = chars;
    ovf_next   = ovf;

    if (pend) begin
      cls_a = CLS_OP;
      end_a = 1'b1;
      if (c == CH_EQ) add_a = 1'b1;
      else fresh = 1'b1;
    end else begin
      unique case (mode)
        MODE_COMMENT: begin
          if (c == CH_LF || c == CH_NUL) begin
            mode_next = MODE_IDLE;
            fresh     = 1'b1;
          end
        end
        MODE_IDENT: begin
          cls_a = CLS_IDENT;
          if (is_alpha(c) || is_digit(c) || c == CH_US) add_a = 1'b1;
          else begin
            end_a = 1'b1;
            fresh = 1'b1;
          end
        end
        MODE_NUMBER: begin
          cls_a = CLS_NUMBER;
          if (is_digit(c)) add_a = 1'b1;
          else begin
            end_a = 1'b1;
            fresh = 1'b1;
          end
        end
        MODE_STRING: begin
          cls_a = CLS_STRING;
          if (c == CH_QUOTE) end_a = 1'b1;
          else if (c == CH_NUL) begin
            end_a = 1'b1;
            fresh = 1'b1;
          end else add_a = 1'b1;
        end
        default: begin
          mode_next = MODE_IDLE;
          fresh     = 1'b1;
        end
      endcase
    end

    if (add_a) begin
      if (chars_next < CW'(TOKEN_CHARS)) begin
        r.slot[n]  = mk(KIND_CHAR, cls_a, c, count_next, 1'b0);
        n          = n + 2'd1;
        chars_next = chars_next + CW'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end

    if (end_a) begin
      r.slot[n]  = mk(KIND_END, cls_a, CH_NUL, count_next, ovf_next);
      n          = n + 2'd1;
      count_next = count_next + 16'd1;
      mode_next  = MODE_IDLE;
      pend_next  = 1'b0;
      chars_next = '0;
      ovf_next   = 1'b0;
    end

    if (fresh) begin
      priority if (c == CH_NUL) begin
        r.slot[n]  = mk(KIND_EOT, CLS_IDENT, CH_NUL, count_next, 1'b0);
        n          = n + 2'd1;
        mode_next  = MODE_IDLE;
        pend_next  = 1'b0;
        count_next = '0;
        chars_next = '0;
        ovf_next   = 1'b0;
      end else if (count_next >= limit || is_space(c)) begin
      end else if (c == CH_HASH) begin
        mode_next = MODE_COMMENT;
      end else if (c == CH_QUOTE) begin
        mode_next  = MODE_STRING;
        chars_next = '0;
        ovf_next   = 1'b0;
      end else if (is_alpha(c) || c == CH_US || is_digit(c)) begin
        mode_next  = is_digit(c) ? MODE_NUMBER : MODE_IDENT;
        r.slot[n]  = mk(KIND_CHAR, is_digit(c) ? CLS_NUMBER : CLS_IDENT, c, count_next, 1'b0);
        n          = n + 2'd1;
        chars_next = CW'(1);
        ovf_next   = 1'b0;
      end else begin
        mode_next = MODE_IDLE;
        r.slot[n] = mk(KIND_CHAR, CLS_OP, c, count_next, 1'b0);
        n         = n + 2'd1;
        ovf_next  = 1'b0;
        if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
          pend_next  = 1'b1;
          chars_next = CW'(1);
        end else begin
          r.slot[n]  = mk(KIND_END, CLS_OP, CH_NUL, count_next, 1'b0);
          n          = n + 2'd1;
          count_next = count_next + 16'd1;
          chars_next = '0;
        end
      end
    end

    if (n != 2'd0) r.slot[n - 2'd1].last_of_run = 1'b1;
    r.count = n;
    step    = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 16'd1024;
      mode  <= MODE_IDLE;
      pend  <= 1'b0;
      count <= '0;
      chars <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_data;
      if (fire) begin
        mode  <= mode_next;
        pend  <= pend_next;
        count <= count_next;
        chars <= chars_next;
        ovf   <= ovf_next;
      end
    end
  end

endmodule

// ===== rtl/stt_outq.sv =====
module stt_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  stt_pkg::step_t step,
  output logic           in_ready,
  output logic           out_valid,
  output stt_pkg::tok_t  out_item,
  input  logic           out_ready
);
  import stt_pkg::*;

  tok_t       slot [MaxResults];
  logic [1:0] cnt;
  logic [1:0] rd;
  logic       pop;

  assign out_valid = cnt != 2'd0;
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);
  assign out_item  = slot[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= '0;
    end else if (load) begin
      cnt <= step.count;
      rd  <= '0;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
      rd  <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MaxResults; i++) slot[i] <= step.slot[i];
    end
  end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// channel | dir | handshake     | payload
// src     | in  | valid / ready | text_byte
// tok     | out | valid / ready | item_kind token_class token_char tokens_so_far
//         |     |               | was_truncated last_of_run
// cfg     | in  | cfg_we        | cfg_data (token_limit)
//
// A byte is scanned in the cycle it transfers; its results appear on tok the next cycle.
// Bytes with at most one result sustain one byte per cycle while tok is ready; a byte with
// more results holds src until the last of them leaves the three-entry result buffer.
// rst is synchronous; token_limit resets to 1024, scanner state to idle, buffer empty.
// src is ready while the buffer is empty or its last result transfers; a stalled tok blocks src.
module source_text_tokenizer #(
  parameter int TOKEN_CHARS = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [15:0] cfg_data,
  stt_byte_if.sink   src,
  stt_tok_if.source  tok
);
  import stt_pkg::*;

  step_t step;
  tok_t  head;
  logic  fire;

  assign fire = src.valid && src.ready;

  stt_scan #(
    .TOKEN_CHARS(TOKEN_CHARS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fire     (fire),
    .text_byte(src.text_byte),
    .step     (step)
  );

  stt_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .step     (step),
    .in_ready (src.ready),
    .out_valid(tok.valid),
    .out_item (head),
    .out_ready(tok.ready)
  );

  assign tok.item_kind     = head.item_kind;
  assign tok.token_class   = head.token_class;
  assign tok.token_char    = head.token_char;
  assign tok.tokens_so_far = head.tokens_so_far;
  assign tok.was_truncated = head.was_truncated;
  assign tok.last_of_run   = head.last_of_run;

  a_results_follow: assert property (@(posedge clk) disable iff (rst)
    (fire && step.count != 2'd0) |=> tok.valid)
    else $error("results of a transferred byte not presented");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (tok.valid && tok.ready && !tok.last_of_run) |=> tok.valid)
    else $error("run ended without last_of_run");

  a_eot_last: assert property (@(posedge clk) disable iff (rst)
    (tok.valid && tok.item_kind == KIND_EOT) |-> tok.last_of_run)
    else $error("end of text not last in run");

endmodule
